// ----- hw/rtl/dtbw_pkg.sv -----
package dtbw_pkg;

	localparam int LITLEN_SYMBOLS = 288;
	localparam int DIST_SYMBOLS   = 32;
	localparam int MAX_CODE_BITS  = 15;
	localparam int LEN_SLOTS      = 29;
	localparam int DIST_SLOTS     = 30;
	localparam int LEN_SYM_BASE   = 257;

	// Input item kinds
	localparam logic [2:0] KIND_LIT   = 3'd0;
	localparam logic [2:0] KIND_MATCH = 3'd1;
	localparam logic [2:0] KIND_RAW   = 3'd2;
	localparam logic [2:0] KIND_FLUSH = 3'd3;
	localparam logic [2:0] KIND_LOADL = 3'd4;
	localparam logic [2:0] KIND_LOADD = 3'd5;

	// Job operations carried between front and back
	localparam logic [2:0] OP_LIT   = 3'd0;
	localparam logic [2:0] OP_MATCH = 3'd1;
	localparam logic [2:0] OP_RAW   = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd3;
	localparam logic [2:0] OP_LOADL = 3'd4;
	localparam logic [2:0] OP_LOADD = 3'd5;

	localparam logic [8:0] LEN_BASE [LEN_SLOTS] = '{
		9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
		9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
		9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
	};
	localparam logic [2:0] LEN_EXTRA [LEN_SLOTS] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
		3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd0
	};
	localparam logic [15:0] DIST_BASE [DIST_SLOTS] = '{
		16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
		16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
		16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
		16'd8193, 16'd12289, 16'd16385, 16'd24577
	};
	localparam logic [3:0] DIST_EXTRA [DIST_SLOTS] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5,
		4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
		4'd11, 4'd12, 4'd12, 4'd13, 4'd13
	};

	typedef struct packed {
		logic [2:0]  op;
		logic [8:0]  lit_addr;
		logic [4:0]  dist_addr;
		logic [4:0]  lx_val;
		logic [2:0]  lx_n;
		logic [12:0] dx_val;
		logic [3:0]  dx_n;
		logic [15:0] raw_val;
		logic [4:0]  raw_n;
		logic [18:0] entry;
	} job_t;

	function automatic logic [4:0] len_slot(input logic [8:0] len);
		logic [4:0] s;
		s = '0;
		for (int i = 0; i < LEN_SLOTS; i++) begin
			if (LEN_BASE[i] <= len) s = 5'(i);
		end
		return s;
	endfunction

	function automatic logic [4:0] dist_slot(input logic [15:0] d);
		logic [4:0] s;
		s = '0;
		for (int i = 0; i < DIST_SLOTS; i++) begin
			if (DIST_BASE[i] <= d) s = 5'(i);
		end
		return s;
	endfunction

endpackage

// ----- hw/rtl/dtbw_front.sv -----
module dtbw_front (
	input  logic              push,
	input  logic              q_full,
	input  logic [2:0]        kind,
	input  logic [8:0]        symbol,
	input  logic [8:0]        match_length,
	input  logic [15:0]       distance,
	input  logic [14:0]       code_word,
	input  logic [3:0]        code_length,
	input  logic [15:0]       raw_value,
	input  logic [4:0]        raw_count,
	output logic              q_push,
	output dtbw_pkg::job_t    q_job
);
	import dtbw_pkg::*;

	logic [8:0]  mlen_c;
	logic [15:0] dist_c;
	logic [4:0]  ls;
	logic [4:0]  dc;
	logic [4:0]  rcnt_c;
	logic [16:0] rmask;
	logic [3:0]  clen_c;
	logic        keep;

	// Clamp match, raw and code-length fields and look up slots
	always_comb begin
		mlen_c = match_length;
		if (match_length < 9'd3) mlen_c = 9'd3;
		if (match_length > 9'd258) mlen_c = 9'd258;
		dist_c = distance;
		if (distance == 16'd0) dist_c = 16'd1;
		if (distance > 16'd32768) dist_c = 16'd32768;
		ls = len_slot(mlen_c);
		dc = dist_slot(dist_c);
		rcnt_c = (raw_count > 5'd16) ? 5'd16 : raw_count;
		rmask = (17'd1 << rcnt_c) - 17'd1;
		clen_c = (32'(code_length) > MAX_CODE_BITS) ? 4'(MAX_CODE_BITS) : code_length;
	end

	// Classify the beat into a job
	always_comb begin
		q_job = '0;
		keep = 1'b0;
		q_job.lit_addr = symbol;
		q_job.dist_addr = dc;
		q_job.lx_n = LEN_EXTRA[ls];
		q_job.lx_val = 5'(mlen_c - LEN_BASE[ls]);
		q_job.dx_n = DIST_EXTRA[dc];
		q_job.dx_val = 13'(dist_c - DIST_BASE[dc]);
		q_job.raw_val = raw_value & rmask[15:0];
		q_job.raw_n = rcnt_c;
		q_job.entry = {clen_c, code_word};
		unique case (kind)
			KIND_LIT: begin
				q_job.op = OP_LIT;
				keep = (32'(symbol) < LITLEN_SYMBOLS);
			end
			KIND_MATCH: begin
				q_job.op = OP_MATCH;
				q_job.lit_addr = 9'(LEN_SYM_BASE + 32'(ls));
				keep = 1'b1;
			end
			KIND_RAW: begin
				q_job.op = OP_RAW;
				keep = 1'b1;
			end
			KIND_FLUSH: begin
				q_job.op = OP_FLUSH;
				keep = 1'b1;
			end
			KIND_LOADL: begin
				q_job.op = OP_LOADL;
				keep = (32'(symbol) < LITLEN_SYMBOLS);
			end
			KIND_LOADD: begin
				q_job.op = OP_LOADD;
				q_job.dist_addr = symbol[4:0];
				keep = (32'(symbol) < DIST_SYMBOLS);
			end
			default: keep = 1'b0;
		endcase
	end

	assign q_push = push && !q_full && keep;

endmodule

// ----- hw/rtl/dtbw_job_fifo.sv -----
module dtbw_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  dtbw_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd,
	output logic           valid,
	output dtbw_pkg::job_t rd_job
);
	import dtbw_pkg::*;

	job_t       mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'd4);
	assign valid = (cnt_q != 3'd0);
	assign rd_job = mem_q[rp_q];

	// Hold job beats
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

endmodule

// ----- hw/rtl/dtbw_back.sv -----
module dtbw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           jf_valid,
	input  dtbw_pkg::job_t jf_job,
	output logic           jf_rd,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);
	import dtbw_pkg::*;

	logic [18:0] lit_mem [LITLEN_SYMBOLS];
	logic [18:0] dist_mem [DIST_SYMBOLS];

	logic        v_s1;
	job_t        job_s1;
	logic [18:0] lit_rd_s1;
	logic [18:0] dist_rd_s1;

	logic        v_s2;
	logic [19:0] seg1_s2;
	logic [4:0]  n1_s2;
	logic [27:0] seg2_s2;
	logic [4:0]  n2_s2;
	logic        flush_s2;

	logic [55:0] acc_q;
	logic [5:0]  cnt_q;

	logic [8:0]  of_q [4];
	logic [1:0]  of_wp_q;
	logic [1:0]  of_rp_q;
	logic [2:0]  of_cnt_q;

	logic        merge;
	logic        emit;
	logic        adv1;
	logic        of_pop;
	logic [3:0]  llen;
	logic [3:0]  dlen;
	logic [14:0] lcode;
	logic [14:0] dcode;
	logic [15:0] lmask;
	logic [15:0] dmask;
	logic [19:0] seg1;
	logic [4:0]  n1;
	logic [27:0] seg2;
	logic [4:0]  n2;
	logic        is_load;

	assign merge = v_s2 && (cnt_q < 6'd8);
	assign emit = (cnt_q >= 6'd8) && (of_cnt_q != 3'd4);
	assign adv1 = !v_s2 || merge;
	assign jf_rd = jf_valid && (!v_s1 || adv1);
	assign is_load = (jf_job.op == OP_LOADL) || (jf_job.op == OP_LOADD);
	assign of_pop = pop && !empty;

	// Table memories: write on loads, read on every job beat
	always_ff @(posedge clk) begin
		if (jf_rd && jf_job.op == OP_LOADL) lit_mem[jf_job.lit_addr] <= jf_job.entry;
		if (jf_rd) lit_rd_s1 <= lit_mem[jf_job.lit_addr];
	end

	always_ff @(posedge clk) begin
		if (jf_rd && jf_job.op == OP_LOADD) dist_mem[jf_job.dist_addr] <= jf_job.entry;
		if (jf_rd) dist_rd_s1 <= dist_mem[jf_job.dist_addr];
	end

	always_ff @(posedge clk) begin
		if (jf_rd) job_s1 <= jf_job;
	end

	// Build bit segments from table entries
	always_comb begin
		llen = lit_rd_s1[18:15];
		dlen = dist_rd_s1[18:15];
		lmask = (16'd1 << llen) - 16'd1;
		dmask = (16'd1 << dlen) - 16'd1;
		lcode = lit_rd_s1[14:0] & lmask[14:0];
		dcode = dist_rd_s1[14:0] & dmask[14:0];
		seg1 = '0;
		n1 = '0;
		seg2 = '0;
		n2 = '0;
		case (job_s1.op)
			OP_LIT: begin
				seg1 = {5'd0, lcode};
				n1 = {1'b0, llen};
			end
			OP_MATCH: begin
				seg1 = {5'd0, lcode} | (20'(job_s1.lx_val) << llen);
				n1 = {1'b0, llen} + {2'd0, job_s1.lx_n};
				seg2 = {13'd0, dcode} | (28'(job_s1.dx_val) << dlen);
				n2 = {1'b0, dlen} + {1'b0, job_s1.dx_n};
			end
			OP_RAW: begin
				seg1 = {4'd0, job_s1.raw_val};
				n1 = job_s1.raw_n;
			end
			default: begin
				seg1 = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv1) begin
			seg1_s2 <= seg1;
			n1_s2 <= n1;
			seg2_s2 <= seg2;
			n2_s2 <= n2;
			flush_s2 <= (job_s1.op == OP_FLUSH);
		end
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (emit) of_q[of_wp_q] <= {(cnt_q < 6'd16), acc_q[7:0]};
	end

	assign empty = (of_cnt_q == 3'd0);
	assign out_byte = of_q[of_rp_q][7:0];
	assign last_of_run = of_q[of_rp_q][8];

	// Control: stage valids, bit buffer, output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			acc_q <= '0;
			cnt_q <= '0;
			of_wp_q <= '0;
			of_rp_q <= '0;
			of_cnt_q <= '0;
		end else begin
			if (jf_rd) v_s1 <= !is_load;
			else if (adv1) v_s1 <= 1'b0;
			if (adv1) v_s2 <= v_s1;
			if (merge) begin
				if (flush_s2) begin
					cnt_q <= (cnt_q == 6'd0) ? 6'd0 : 6'd8;
				end else begin
					acc_q <= {48'd0, acc_q[7:0]}
						| (56'(seg1_s2) << cnt_q)
						| (56'(seg2_s2) << (cnt_q + 6'(n1_s2)));
					cnt_q <= cnt_q + 6'(n1_s2) + 6'(n2_s2);
				end
			end else if (emit) begin
				acc_q <= acc_q >> 8;
				cnt_q <= cnt_q - 6'd8;
			end
			if (emit) of_wp_q <= of_wp_q + 2'd1;
			if (of_pop) of_rp_q <= of_rp_q + 2'd1;
			of_cnt_q <= of_cnt_q + {2'd0, emit} - {2'd0, of_pop};
		end
	end

endmodule

// ----- hw/rtl/deflate_token_bit_writer_unit.sv -----
// An item's bytes pass through the job queue, table read, segment build, bit buffer and output queue.
// Throughput: the input takes one item per cycle until the four-deep job queue fills.
// The byte packer merges an item's bits into the bit buffer, then emits its bytes one by one while
// the output queue has room; it merges no new item until fewer than eight bits are buffered.
// Reset (arst_n low) empties all queues and clears the bit buffer; code tables
// hold nothing defined until loaded and need no clearing pass.
module deflate_token_bit_writer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [8:0]  symbol,
	input  logic [8:0]  match_length,
	input  logic [15:0] distance,
	input  logic [14:0] code_word,
	input  logic [3:0]  code_length,
	input  logic [15:0] raw_value,
	input  logic [4:0]  raw_count,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);
	import dtbw_pkg::*;

	logic q_push;
	logic q_full;
	logic q_rd;
	logic q_valid;
	job_t q_wjob;
	job_t q_rjob;

	assign full = q_full;

	dtbw_front u_front (
		.push         (push),
		.q_full       (q_full),
		.kind         (kind),
		.symbol       (symbol),
		.match_length (match_length),
		.distance     (distance),
		.code_word    (code_word),
		.code_length  (code_length),
		.raw_value    (raw_value),
		.raw_count    (raw_count),
		.q_push       (q_push),
		.q_job        (q_wjob)
	);

	dtbw_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_job (q_wjob),
		.full   (q_full),
		.rd     (q_rd),
		.valid  (q_valid),
		.rd_job (q_rjob)
	);

	dtbw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.jf_valid    (q_valid),
		.jf_job      (q_rjob),
		.jf_rd       (q_rd),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

// ----- test/tb_deflate_token_bit_writer_unit.sv -----
`timescale 1ns / 100ps

module tb_deflate_token_bit_writer_unit;
	import dtbw_pkg::*;

	typedef struct {
		logic [2:0]  kind;
		logic [8:0]  symbol;
		logic [8:0]  match_length;
		logic [15:0] distance;
		logic [14:0] code_word;
		logic [3:0]  code_length;
		logic [15:0] raw_value;
		logic [4:0]  raw_count;
	} token_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  kind;
	logic [8:0]  symbol;
	logic [8:0]  match_length;
	logic [15:0] distance;
	logic [14:0] code_word;
	logic [3:0]  code_length;
	logic [15:0] raw_value;
	logic [4:0]  raw_count;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        last_of_run;

	token_t    token_queue[$];
	out_beat_t expected_bytes[$];
	out_beat_t token_bytes[$];

	// bit packer state mirrored from the block
	logic [18:0] litlen_codes [LITLEN_SYMBOLS];
	logic [18:0] dist_codes [DIST_SYMBOLS];
	logic [63:0] pack_acc;
	int          pack_count;

	// entries already loaded, tracked at generation time
	bit          lit_loaded [LITLEN_SYMBOLS];
	bit          dist_loaded [DIST_SYMBOLS];
	int          loaded_lits[$];

	int  err_count;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_cycles;
	bit  took;

	deflate_token_bit_writer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.symbol(symbol), .match_length(match_length), .distance(distance),
		.code_word(code_word), .code_length(code_length), .raw_value(raw_value),
		.raw_count(raw_count), .empty(empty), .pop(pop), .out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int length_slot(input int len);
		int s;
		s = 0;
		for (int i = 0; i < LEN_SLOTS; i++) begin
			if (LEN_BASE[i] <= len) s = i;
		end
		return s;
	endfunction

	function automatic int distance_slot(input int d);
		int s;
		s = 0;
		for (int i = 0; i < DIST_SLOTS; i++) begin
			if (DIST_BASE[i] <= d) s = i;
		end
		return s;
	endfunction

	// append n bits LSB first, collecting completed bytes
	function automatic void pack_bits(input logic [31:0] value, input int n);
		logic [63:0] v;
		out_beat_t ob;
		if (n > 16) n = 16;
		v = 64'(value) & ((64'd1 << n) - 64'd1);
		pack_acc = pack_acc | (v << pack_count);
		pack_count = pack_count + n;
		while (pack_count >= 8) begin
			ob.data = pack_acc[7:0];
			ob.last = 1'b0;
			token_bytes.push_back(ob);
			pack_acc = pack_acc >> 8;
			pack_count = pack_count - 8;
		end
	endfunction

	function automatic void pack_code(input logic [18:0] entry);
		pack_bits({17'd0, entry[14:0]}, int'(entry[18:15]));
	endfunction

	function automatic logic [18:0] code_entry(input logic [14:0] w, input logic [3:0] l);
		logic [3:0] len;
		len = (l > MAX_CODE_BITS) ? 4'(MAX_CODE_BITS) : l;
		return {len, w};
	endfunction

	// predict the bytes caused by one accepted token
	function automatic void predict_bytes(input token_t t);
		int ml, d, ls, dc, rc;
		token_bytes.delete();
		case (t.kind)
			KIND_LIT: begin
				if (t.symbol < LITLEN_SYMBOLS) pack_code(litlen_codes[t.symbol]);
			end
			KIND_MATCH: begin
				ml = t.match_length;
				d = t.distance;
				if (ml < 3) ml = 3;
				if (ml > 258) ml = 258;
				if (d < 1) d = 1;
				if (d > 32768) d = 32768;
				ls = length_slot(ml);
				dc = distance_slot(d);
				pack_code(litlen_codes[LEN_SYM_BASE + ls]);
				pack_bits(32'(ml - LEN_BASE[ls]), int'(LEN_EXTRA[ls]));
				pack_code(dist_codes[dc]);
				pack_bits(32'(d - DIST_BASE[dc]), int'(DIST_EXTRA[dc]));
			end
			KIND_RAW: begin
				rc = t.raw_count;
				pack_bits({16'd0, t.raw_value}, rc);
			end
			KIND_FLUSH: begin
				if (pack_count != 0) pack_bits(32'd0, 8 - pack_count);
			end
			KIND_LOADL: begin
				if (t.symbol < LITLEN_SYMBOLS)
					litlen_codes[t.symbol] = code_entry(t.code_word, t.code_length);
			end
			KIND_LOADD: begin
				if (t.symbol < DIST_SYMBOLS)
					dist_codes[t.symbol] = code_entry(t.code_word, t.code_length);
			end
			default: ;
		endcase
		if (token_bytes.size() > 0) token_bytes[token_bytes.size() - 1].last = 1'b1;
		foreach (token_bytes[i]) expected_bytes.push_back(token_bytes[i]);
	endfunction

	function automatic token_t noise_token();
		token_t t;
		t.kind = 3'($urandom);
		t.symbol = 9'($urandom);
		t.match_length = 9'($urandom);
		t.distance = 16'($urandom);
		t.code_word = 15'($urandom);
		t.code_length = 4'($urandom);
		t.raw_value = 16'($urandom);
		t.raw_count = 5'($urandom);
		return t;
	endfunction

	// queue a token, tracking which code entries become defined
	task automatic queue_token(input token_t t);
		if (t.kind == KIND_LOADL && t.symbol < LITLEN_SYMBOLS && !lit_loaded[t.symbol]) begin
			lit_loaded[t.symbol] = 1'b1;
			if (t.symbol < LEN_SYM_BASE - 1 + 1) loaded_lits.push_back(t.symbol);
		end
		if (t.kind == KIND_LOADD && t.symbol < DIST_SYMBOLS) dist_loaded[t.symbol] = 1'b1;
		token_queue.push_back(t);
	endtask

	task automatic queue_load(input logic [2:0] k, input int sym);
		token_t t;
		t = noise_token();
		t.kind = k;
		t.symbol = 9'(sym);
		queue_token(t);
	endtask

	task automatic queue_match(input int ml, input int d);
		token_t t;
		int cml, cd;
		cml = (ml < 3) ? 3 : (ml > 258 ? 258 : ml);
		cd = (d < 1) ? 1 : d;
		if (!lit_loaded[LEN_SYM_BASE + length_slot(cml)])
			queue_load(KIND_LOADL, LEN_SYM_BASE + length_slot(cml));
		if (!dist_loaded[distance_slot(cd)]) queue_load(KIND_LOADD, distance_slot(cd));
		t = noise_token();
		t.kind = KIND_MATCH;
		t.match_length = 9'(ml);
		t.distance = 16'(d);
		queue_token(t);
	endtask

	task automatic queue_simple(input logic [2:0] k, input int sym, input int rv,
			input int rc);
		token_t t;
		t = noise_token();
		t.kind = k;
		t.symbol = 9'(sym);
		t.raw_value = 16'(rv);
		t.raw_count = 5'(rc);
		queue_token(t);
	endtask

	task automatic queue_random_token();
		token_t t;
		int pick, ml, d, sel;
		pick = $urandom_range(99);
		if (pick < 33 && loaded_lits.size() > 0) begin
			t = noise_token();
			t.kind = KIND_LIT;
			t.symbol = 9'(loaded_lits[$urandom_range(loaded_lits.size() - 1)]);
			queue_token(t);
		end else if (pick < 60) begin
			sel = $urandom_range(9);
			ml = (sel == 0) ? $urandom_range(511) : $urandom_range(3, 258);
			if (sel == 1) d = $urandom_range(65535);
			else d = $urandom_range(1, 1 << $urandom_range(0, 15));
			queue_match(ml, d);
		end else if (pick < 75) begin
			queue_simple(KIND_RAW, $urandom, $urandom,
				($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16));
		end else if (pick < 82) begin
			queue_simple(KIND_FLUSH, $urandom, $urandom, $urandom);
		end else if (pick < 92) begin
			queue_load(KIND_LOADL, ($urandom_range(9) == 0) ? $urandom_range(511)
				: $urandom_range(LITLEN_SYMBOLS - 1));
		end else if (pick < 96) begin
			queue_load(KIND_LOADD, ($urandom_range(5) == 0) ? $urandom_range(511)
				: $urandom_range(DIST_SYMBOLS - 1));
		end else begin
			// ignored kinds
			queue_simple(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom);
		end
	endtask

	task automatic wait_drained();
		while (token_queue.size() > 0 || expected_bytes.size() > 0 || push)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// drive tokens at the falling edge; hold an offered beat until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !took) begin
			push <= 1'b1;
		end else if (token_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			kind <= token_queue[0].kind;
			symbol <= token_queue[0].symbol;
			match_length <= token_queue[0].match_length;
			distance <= token_queue[0].distance;
			code_word <= token_queue[0].code_word;
			code_length <= token_queue[0].code_length;
			raw_value <= token_queue[0].raw_value;
			raw_count <= token_queue[0].raw_count;
		end else begin
			push <= 1'b0;
		end
	end

	// stall the byte side at random, or hold off for a counted stretch
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_cycles > 0) begin
			pop <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// accept tokens into the predictor and check bytes
	always @(posedge clk) begin
		took = 1'b0;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
			if (push && !full) begin
				took = 1'b1;
				predict_bytes(token_queue.pop_front());
			end
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte out_byte=%h last_of_run=%b", out_byte, last_of_run);
					err_count++;
				end else begin
					if (out_byte !== expected_bytes[0].data) begin
						$error("out_byte expected %h actual %h", expected_bytes[0].data, out_byte);
						err_count++;
					end
					if (last_of_run !== expected_bytes[0].last) begin
						$error("last_of_run expected %b actual %b", expected_bytes[0].last,
							last_of_run);
						err_count++;
					end
					void'(expected_bytes.pop_front());
				end
			end
		end
	end

	initial begin
		int idle_set [4];
		int stall_set [4];
		idle_set = '{0, 61, 0, 35};
		stall_set = '{0, 0, 61, 35};
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		kind = '0;
		symbol = '0;
		match_length = '0;
		distance = '0;
		code_word = '0;
		code_length = '0;
		raw_value = '0;
		raw_count = '0;
		pack_acc = '0;
		pack_count = 0;
		err_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		took = 1'b0;
		foreach (litlen_codes[i]) litlen_codes[i] = '0;
		foreach (dist_codes[i]) dist_codes[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: table extremes, every kind, saturation and ignored cases
		queue_load(KIND_LOADL, 0);
		queue_load(KIND_LOADL, LITLEN_SYMBOLS - 1);
		queue_load(KIND_LOADL, 256);
		queue_load(KIND_LOADL, 300);
		queue_load(KIND_LOADD, 40);
		queue_simple(KIND_LIT, 0, 0, 0);
		queue_simple(KIND_LIT, LITLEN_SYMBOLS - 1, 0, 0);
		queue_simple(KIND_LIT, 256, 0, 0);
		queue_simple(KIND_LIT, 511, 0, 0);
		queue_match(3, 1);
		queue_match(258, 32768);
		queue_match(10, 4);
		queue_match(0, 0);
		queue_match(511, 65535);
		queue_simple(KIND_RAW, 0, 16'hFFFF, 16);
		queue_simple(KIND_RAW, 0, 16'hA5C3, 0);
		queue_simple(KIND_RAW, 0, 16'h5A3C, 31);
		queue_simple(KIND_RAW, 0, 16'h0001, 3);
		queue_simple(KIND_FLUSH, 0, 0, 0);
		queue_simple(KIND_FLUSH, 0, 0, 0);
		queue_simple(3'd6, 0, 0, 0);
		queue_simple(3'd7, 0, 0, 0);
		wait_drained();

		// long receiver hold while tokens keep coming, then idling phases
		hold_cycles = 300;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_set[ph];
			recv_stall_pct = stall_set[ph];
			for (int n = 0; n < 120; n++) queue_random_token();
			wait_drained();
		end

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/dtbw_pkg.sv
hw/rtl/dtbw_front.sv
hw/rtl/dtbw_job_fifo.sv
hw/rtl/dtbw_back.sv
hw/rtl/deflate_token_bit_writer_unit.sv
test/tb_deflate_token_bit_writer_unit.sv
